/* src/stern_brocot_path_encoder_assert.svh */
// Assertion macros for the path encoder.
`ifndef STERN_BROCOT_PATH_ENCODER_ASSERT_SVH
`define STERN_BROCOT_PATH_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
`define SBPE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SBPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SBPE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SBPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/sbpe_pkg.sv */
package sbpe_pkg;

   localparam int unsigned VALUE_BITS_DEFAULT = 32;
   localparam int unsigned MAX_RUNS           = 48;
   localparam int unsigned RUN_CNT_BITS       = $clog2(MAX_RUNS);

   localparam logic [1:0] STATUS_PATH    = 2'd0;
   localparam logic [1:0] STATUS_ROOT    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

/* src/stern_brocot_path_encoder.sv */
// Stern-Brocot path encoder.
// Input: pulse start with req_numerator / req_denominator while busy is low;
// the beat is taken at that edge. Operands are cut to VALUE_BITS bits (at
// most 32). Output: every result beat is shown for one cycle with rsp_valid;
// the receiver cannot hold it off. Each beat is one run of the path:
// rsp_direction (0 left, 1 right), rsp_run_length, rsp_last on the final run.
// A zero operand gives a single invalid status beat, equal operands a single
// root status beat; both appear the cycle after start and busy stays low.
// Otherwise busy rises and each quotient costs one restoring division on a
// shared one-bit-per-cycle divider plus one emit state; 32-bit operands
// need at most 46 divisions. A fraction below one spends its first division
// on an empty quotient. No new item is taken while busy is high; one can be
// taken once busy is low. Reset (synchronous, active high) returns the block
// to idle with no beat pending.
module stern_brocot_path_encoder #(
   parameter int unsigned VALUE_BITS = sbpe_pkg::VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_numerator,
   input  logic [31:0] req_denominator,
   output logic        rsp_valid,
   output logic        rsp_direction,
   output logic [31:0] rsp_run_length,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);
   import sbpe_pkg::*;

   localparam int unsigned W  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int unsigned CW = $clog2(W);

   state_type state_ff, state_in;

   logic [W-1:0]            quo_ff, quo_in;
   logic [W-1:0]            den_ff, den_in;
   logic [W-1:0]            rem_ff, rem_in;
   logic [CW-1:0]           bit_cnt_ff, bit_cnt_in;
   logic [RUN_CNT_BITS-1:0] runs_ff, runs_in;
   logic                    right_ff, right_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_dir_ff, rsp_dir_in;
   logic [31:0] rsp_len_ff, rsp_len_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic [W-1:0] op_num, op_den;
   logic         accept;
   logic [W+1:0] trial;
   logic         rem_zero;
   logic [W-1:0] term;
   logic         final_run;

   assign op_num    = req_numerator[W-1:0];
   assign op_den    = req_denominator[W-1:0];
   assign accept    = start && (state_ff == ST_IDLE);
   assign trial     = {1'b0, rem_ff, quo_ff[W-1]} - {2'b00, den_ff};
   assign rem_zero  = (rem_ff == '0);
   assign term      = rem_zero ? (quo_ff - W'(1)) : quo_ff;
   assign final_run = rem_zero || (runs_ff == RUN_CNT_BITS'(MAX_RUNS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && op_num != '0 && op_den != '0 && op_num != op_den) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (bit_cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (term != '0 && final_run) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      quo_in        = quo_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      runs_in       = runs_ff;
      right_in      = right_ff;
      rsp_valid_in  = 1'b0;
      rsp_dir_in    = DIR_LEFT;
      rsp_len_in    = '0;
      rsp_last_in   = 1'b1;
      rsp_status_in = STATUS_PATH;
      case (state_ff)
         ST_IDLE: begin
            quo_in     = op_num;
            den_in     = op_den;
            rem_in     = '0;
            bit_cnt_in = CW'(W - 1);
            runs_in    = '0;
            right_in   = DIR_RIGHT;
            if (accept && (op_num == '0 || op_den == '0)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_INVALID;
            end else if (accept && op_num == op_den) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_ROOT;
            end
         end
         ST_DIVIDE: begin
            quo_in     = {quo_ff[W-2:0], ~trial[W+1]};
            rem_in     = trial[W+1] ? {rem_ff[W-2:0], quo_ff[W-1]} : trial[W-1:0];
            bit_cnt_in = bit_cnt_ff - CW'(1);
         end
         ST_EMIT: begin
            quo_in     = den_ff;
            den_in     = rem_ff;
            rem_in     = '0;
            bit_cnt_in = CW'(W - 1);
            right_in   = ~right_ff;
            if (term != '0) begin
               runs_in      = runs_ff + RUN_CNT_BITS'(1);
               rsp_valid_in = 1'b1;
               rsp_dir_in   = right_ff;
               rsp_len_in   = 32'(term);
               rsp_last_in  = final_run;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      bit_cnt_ff    <= bit_cnt_in;
      runs_ff       <= runs_in;
      right_ff      <= right_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_run_length = rsp_len_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

`include "stern_brocot_path_encoder_assert.svh"

   `SBPE_ASSERT_IMPL(a_status_is_last, clock, reset,
      rsp_valid && rsp_status != STATUS_PATH, rsp_last)
   `SBPE_ASSERT_IMPL(a_run_nonzero, clock, reset,
      rsp_valid && rsp_status == STATUS_PATH, rsp_run_length != 32'd0)
   `SBPE_ASSERT_IMPL(a_more_runs_busy, clock, reset,
      rsp_valid && !rsp_last, busy)
   `SBPE_ASSERT_NEXT(a_zero_invalid, clock, reset,
      start && !busy && (op_num == '0 || op_den == '0),
      rsp_valid && rsp_status == STATUS_INVALID)

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import sbpe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        dir;
      logic [31:0] len;
      logic        last;
      logic [1:0]  status;
   } run_beat_t;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_numerator;
   logic [31:0] req_denominator;
   logic        rsp_valid;
   logic        rsp_direction;
   logic [31:0] rsp_run_length;
   logic        rsp_last;
   logic [1:0]  rsp_status;

   run_beat_t   expected_runs[$];
   run_beat_t   want;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // walk bounds as tracked by the path predictor
   logic [31:0] lo_num, lo_den, hi_num, hi_den;
   logic        heading_left;

   stern_brocot_path_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .rsp_valid       (rsp_valid),
      .rsp_direction   (rsp_direction),
      .rsp_run_length  (rsp_run_length),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Euclid chain: each nonzero quotient is one run; the final one is cut by one.
   function automatic void predict_path(input logic [31:0] num, input logic [31:0] den);
      logic [63:0] p, q, quo, rem;
      logic        dir;
      int          runs;
      run_beat_t   pend;
      p = num;
      q = den;
      dir = DIR_RIGHT;
      runs = 0;
      pend = '{DIR_LEFT, 32'd0, 1'b1, STATUS_ROOT};
      lo_num = 32'd0;
      lo_den = 32'd1;
      hi_num = 32'd1;
      hi_den = 32'd0;
      heading_left = 1'b0;
      if (p == 0 || q == 0) begin
         expected_runs.push_back('{DIR_LEFT, 32'd0, 1'b1, STATUS_INVALID});
         return;
      end
      if (p == q) begin
         expected_runs.push_back(pend);
         return;
      end
      while (q != 0 && runs < sbpe_pkg::MAX_RUNS) begin
         quo = p / q;
         rem = p % q;
         if (rem == 0 && quo > 0)
            quo = quo - 1;
         if (quo > 0) begin
            if (dir == DIR_RIGHT) begin
               lo_num = lo_num + quo[31:0] * hi_num;
               lo_den = lo_den + quo[31:0] * hi_den;
            end else begin
               hi_num = hi_num + quo[31:0] * lo_num;
               hi_den = hi_den + quo[31:0] * lo_den;
            end
            heading_left = (dir == DIR_LEFT);
            if (runs > 0)
               expected_runs.push_back(pend);
            pend = '{dir, quo[31:0], 1'b0, STATUS_PATH};
            runs++;
         end
         p = q;
         q = rem;
         dir = ~dir;
      end
      pend.last = 1'b1;
      expected_runs.push_back(pend);
   endfunction

   function automatic logic [31:0] fib(input int n);
      logic [63:0] a, b, t;
      a = 0;
      b = 1;
      repeat (n) begin
         t = a + b;
         a = b;
         b = t;
      end
      return a[31:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_runs.size() == 0) begin
            $error("unexpected beat: dir %0d len %0d last %0d status %0d",
                   rsp_direction, rsp_run_length, rsp_last, rsp_status);
            mismatch_count++;
         end else begin
            want = expected_runs[0];
            expected_runs.delete(0);
            if (rsp_direction !== want.dir) begin
               $error("direction: expected %0d, got %0d", want.dir, rsp_direction);
               mismatch_count++;
            end
            if (rsp_run_length !== want.len) begin
               $error("run_length: expected %0d, got %0d", want.len, rsp_run_length);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // start stays high on return; the next call must be send_fraction or hold_off
   task automatic send_fraction(input logic [31:0] num, input logic [31:0] den);
      @(negedge clock);
      start <= 1'b1;
      req_numerator <= num;
      req_denominator <= den;
      do @(posedge clock); while (busy);
      predict_path(num, den);
   endtask

   task automatic hold_off(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_numerator <= $urandom;
         req_denominator <= $urandom;
      end
   endtask

   task automatic wait_all_done();
      hold_off(1);
      while (expected_runs.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_fraction(output logic [31:0] num, output logic [31:0] den);
      logic [31:0] a, b, k, x;
      int          n;
      case ($urandom_range(0, 9))
         4: begin
            num = $urandom_range(1, 64);
            den = $urandom_range(1, 64);
         end
         5: begin
            a = $urandom_range(1, 1000);
            b = $urandom_range(1, 1000);
            k = $urandom_range(1, ALL_ONES / ((a > b) ? a : b));
            num = a * k;
            den = b * k;
         end
         6: begin
            n = $urandom_range(1, 46);
            if ($urandom_range(0, 1)) begin
               num = fib(n);
               den = fib(n + 1);
            end else begin
               num = fib(n + 1);
               den = fib(n);
            end
         end
         7: begin
            x = $urandom;
            case ($urandom_range(0, 2))
               0: begin num = 32'd0; den = x; end
               1: begin num = x; den = 32'd0; end
               default: begin num = x; den = x; end
            endcase
         end
         8: begin
            num = $urandom >> $urandom_range(0, 31);
            den = $urandom >> $urandom_range(0, 31);
         end
         9: begin
            x = $urandom_range(3, ALL_ONES - 3);
            num = x;
            den = $urandom_range(0, 1) ? x + $urandom_range(1, 3) : x - $urandom_range(1, 3);
         end
         default: begin
            num = $urandom;
            den = $urandom;
         end
      endcase
   endtask

   task automatic test_directed_cases();
      send_fraction(32'd0, 32'd0);
      send_fraction(32'd0, ALL_ONES);
      send_fraction(ALL_ONES, 32'd0);
      send_fraction(32'd1, 32'd1);
      send_fraction(ALL_ONES, ALL_ONES);
      send_fraction(32'd5, 32'd5);
      send_fraction(32'd1, ALL_ONES);
      send_fraction(ALL_ONES, 32'd1);
      send_fraction(32'd1, 32'd2);
      send_fraction(32'd2, 32'd1);
      send_fraction(32'd3, 32'd2);
      send_fraction(32'd6, 32'd4);
      send_fraction(32'd3, 32'd7);
      send_fraction(ALL_ONES, ALL_ONES - 1);
      send_fraction(ALL_ONES - 1, ALL_ONES);
      send_fraction(fib(47), fib(46));
      send_fraction(fib(46), fib(47));
      send_fraction(32'h8000_0000, 32'd1);
      send_fraction(32'd1, 32'h8000_0000);
      send_fraction(32'hAAAA_AAAA, 32'h5555_5555);
      send_fraction(32'h5555_5555, 32'hAAAA_AAAB);
      send_fraction(32'd0, 32'd1);
      hold_off(1);
   endtask

   task automatic test_random_fractions(input int unsigned count);
      logic [31:0] num, den;
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 17));
         random_fraction(num, den);
         send_fraction(num, den);
      end
      hold_off(1);
   endtask

   // sender waits for every expected beat after each group of fractions before going on
   task automatic test_drain_pause();
      logic [31:0] num, den;
      repeat (2) begin
         repeat (3) begin
            random_fraction(num, den);
            send_fraction(num, den);
         end
         wait_all_done();
         send_fraction(32'd0, $urandom);
         send_fraction($urandom, $urandom);
         wait_all_done();
      end
   endtask

   task automatic test_back_to_back(input int unsigned count);
      logic [31:0] num, den;
      repeat (4)
         send_fraction($urandom, 32'd0);
      repeat (4)
         send_fraction(32'd9, 32'd9);
      repeat (count) begin
         random_fraction(num, den);
         send_fraction(num, den);
      end
      wait_all_done();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_numerator = '0;
      req_denominator = '0;
      mismatch_count = 0;
      cycle_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_fractions(280);
      test_drain_pause();
      test_back_to_back(48);

      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_runs.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/sbpe_pkg.sv
src/stern_brocot_path_encoder.sv
dv/testbench.sv
